@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and masked during reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/c2c_pkg.sv @@
// Constants and codes for the COO to CSR builder.
package c2c_pkg;

	localparam int MAX_ROWS    = 256;
	localparam int MAX_ENTRIES = 1024;
	localparam int COL_BITS    = 16;

	localparam int ENT_AW    = $clog2(MAX_ENTRIES);
	localparam int CNT_W     = ENT_AW + 1;
	localparam int ROW_AW    = $clog2(MAX_ROWS);
	localparam int OFF_DEPTH = MAX_ROWS + 1;
	localparam int OFF_AW    = ROW_AW + 1;

	localparam logic [1:0] OP_LOAD     = 2'd0;
	localparam logic [1:0] OP_BUILD    = 2'd1;
	localparam logic [1:0] OP_READ_OFF = 2'd2;
	localparam logic [1:0] OP_READ_COL = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OOB      = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	localparam logic [1:0] REG_NUM_ROWS = 2'd0;
	localparam logic [1:0] REG_NUM_COLS = 2'd1;
	localparam logic [1:0] REG_SORTED   = 2'd2;
	localparam logic [1:0] REG_NO_DUPS  = 2'd3;

endpackage

@@ rtl/c2c_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module c2c_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ rtl/coo_to_csr_builder_core.sv @@
// Top level: COO to CSR builder with its sequencer and working memories.
//
// Input channel (in_valid / in_stall) takes one item per transfer: opcode, row,
// col, position. Loads give no result; build and reads give one result on the
// output channel (out_valid / out_stall): status, value, nonzeros.
// Loads can follow back to back. An out of range read shows its result in the
// cycle after the transfer; an in range read first passes the S_RD_OFF or
// S_RD_COL state, which takes the registered memory data.
// A build walks the stored state with one sequencer and one write and one read
// port per memory: a bounds check, clearing the offset table, counting,
// scanning, scattering, the per-row insertion sort (skipped when sorted is
// set), duplicate removal (skipped when no_dups is set) and filling the tail
// of the offset table. A failed check ends the build after the clear.
// After reset the block runs a pass that zeroes the offset table; in_stall is
// high meanwhile. Configuration writes are taken at any time and
// cfg_ready is always high.
// in_stall stays high while an item is at work or a result waits; a stalled
// result holds its fields until the transfer.
module coo_to_csr_builder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  row,
	input  logic [15:0] col,
	input  logic [10:0] position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] value,
	output logic [10:0] nonzeros,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import c2c_pkg::*;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_RD_OFF, S_RD_COL,
		S_CHK_A, S_CHK_B, S_CHK_END,
		S_CNT_A, S_CNT_B, S_CNT_C, S_CNT_D,
		S_SCAN_A, S_SCAN_B,
		S_SCAT_A, S_SCAT_B, S_SCAT_C, S_SCAT_D,
		S_SRT_R, S_SRT_RB, S_SRT_A, S_SRT_V, S_SRT_P, S_SRT_C,
		S_DED_R, S_DED_E, S_DED_K, S_DED_D,
		S_FILL
	} state_t;

	state_t state_q;

	logic [8:0]          num_rows_q;
	logic [16:0]         num_cols_q;
	logic                sorted_q;
	logic                no_dups_q;
	logic [CNT_W-1:0]    load_count_q;
	logic                ovf_q;
	logic [CNT_W-1:0]    built_q;
	logic                boot_q;
	logic                bad_q;
	logic [1:0]          st_q;
	logic [CNT_W-1:0]    n_q, k_q, run_q, w_q, a_q, b_q, e_q, p_q;
	logic [OFF_AW-1:0]   i_q, clr_q;
	logic [7:0]          row_q;
	logic [COL_BITS-1:0] col_q, v_q, prev_q;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [15:0]         value_q;
	logic [OFF_AW-1:0]   nr;

	// memory ports
	logic                we_ld;
	logic [ENT_AW-1:0]   ld_waddr, ld_raddr;
	logic [7:0]          rows_rdata;
	logic [COL_BITS-1:0] cols_rdata;
	logic                off_we;
	logic [OFF_AW-1:0]   off_waddr, off_raddr;
	logic [CNT_W-1:0]    off_wdata, off_rdata;
	logic                cur_we;
	logic [ROW_AW-1:0]   cur_waddr, cur_raddr;
	logic [CNT_W-1:0]    cur_wdata, cur_rdata;
	logic                cs_we;
	logic [ENT_AW-1:0]   cs_waddr, cs_raddr;
	logic [COL_BITS-1:0] cs_wdata, cs_rdata;

	logic accept;

	assign nr        = (num_rows_q > 9'd256) ? 9'd256 : num_rows_q;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value     = value_q;
	assign nonzeros  = built_q;
	assign cfg_ready = 1'b1;

	c2c_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES)) u_rows (
		.clk, .we(we_ld), .waddr(ld_waddr), .wdata(row),
		.raddr(ld_raddr), .rdata(rows_rdata)
	);
	c2c_ram #(.WIDTH(COL_BITS), .DEPTH(MAX_ENTRIES)) u_cols (
		.clk, .we(we_ld), .waddr(ld_waddr), .wdata(col),
		.raddr(ld_raddr), .rdata(cols_rdata)
	);
	c2c_ram #(.WIDTH(CNT_W), .DEPTH(OFF_DEPTH)) u_off (
		.clk, .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
		.raddr(off_raddr), .rdata(off_rdata)
	);
	c2c_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS)) u_cur (
		.clk, .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
		.raddr(cur_raddr), .rdata(cur_rdata)
	);
	c2c_ram #(.WIDTH(COL_BITS), .DEPTH(MAX_ENTRIES)) u_store (
		.clk, .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
		.raddr(cs_raddr), .rdata(cs_rdata)
	);

	always_comb begin
		we_ld     = accept && (opcode == OP_LOAD) && !load_count_q[ENT_AW];
		ld_waddr  = load_count_q[ENT_AW-1:0];
		ld_raddr  = k_q[ENT_AW-1:0];
		off_we    = 1'b0;
		off_waddr = i_q;
		off_wdata = '0;
		off_raddr = i_q;
		cur_we    = 1'b0;
		cur_waddr = row_q;
		cur_wdata = '0;
		cur_raddr = row_q;
		cs_we     = 1'b0;
		cs_waddr  = p_q[ENT_AW-1:0];
		cs_wdata  = v_q;
		cs_raddr  = position[ENT_AW-1:0];
		unique case (state_q)
			S_CLR: begin
				off_we    = 1'b1;
				off_waddr = clr_q;
				cur_we    = !clr_q[ROW_AW];
				cur_waddr = clr_q[ROW_AW-1:0];
			end
			S_IDLE: begin
				off_raddr = position[OFF_AW-1:0];
			end
			S_CNT_C: begin
				off_raddr = {1'b0, row_q};
			end
			S_CNT_D: begin
				off_we    = 1'b1;
				off_waddr = {1'b0, row_q};
				off_wdata = off_rdata + CNT_W'(1);
			end
			S_SCAN_B: begin
				off_we    = 1'b1;
				off_wdata = run_q;
				cur_we    = (i_q < nr);
				cur_waddr = i_q[ROW_AW-1:0];
				cur_wdata = run_q;
			end
			S_SCAT_D: begin
				cs_we     = 1'b1;
				cs_waddr  = cur_rdata[ENT_AW-1:0];
				cs_wdata  = col_q;
				cur_we    = 1'b1;
				cur_wdata = cur_rdata + CNT_W'(1);
			end
			S_SRT_R: begin
				cur_raddr = i_q[ROW_AW-1:0];
			end
			S_SRT_A: begin
				cs_raddr = a_q[ENT_AW-1:0];
			end
			S_SRT_P: begin
				cs_raddr = 10'(p_q - CNT_W'(1));
				cs_we    = !(p_q > b_q);
			end
			S_SRT_C: begin
				cs_we    = 1'b1;
				cs_wdata = (cs_rdata > v_q) ? cs_rdata : v_q;
			end
			S_DED_R: begin
				cur_raddr = i_q[ROW_AW-1:0];
			end
			S_DED_E: begin
				off_we    = 1'b1;
				off_wdata = w_q;
			end
			S_DED_K: begin
				cs_raddr = k_q[ENT_AW-1:0];
			end
			S_DED_D: begin
				cs_we    = (k_q == b_q) || (cs_rdata != prev_q);
				cs_waddr = w_q[ENT_AW-1:0];
				cs_wdata = cs_rdata;
			end
			S_FILL: begin
				off_we    = 1'b1;
				off_wdata = w_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			num_rows_q   <= 9'd256;
			num_cols_q   <= 17'd65536;
			sorted_q     <= 1'b0;
			no_dups_q    <= 1'b0;
			load_count_q <= '0;
			ovf_q        <= 1'b0;
			built_q      <= '0;
			boot_q       <= 1'b1;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_NUM_ROWS: num_rows_q <= cfg_data[8:0];
					REG_NUM_COLS: num_cols_q <= cfg_data;
					REG_SORTED:   sorted_q   <= cfg_data[0];
					REG_NO_DUPS:  no_dups_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + OFF_AW'(1);
					if (clr_q == OFF_AW'(MAX_ROWS)) begin
						if (boot_q) begin
							boot_q  <= 1'b0;
							state_q <= S_IDLE;
						end else if (st_q != ST_OK) begin
							out_valid_q <= 1'b1;
							status_q    <= st_q;
							value_q     <= '0;
							state_q     <= S_IDLE;
						end else begin
							k_q     <= '0;
							state_q <= S_CNT_A;
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (opcode)
							OP_LOAD: begin
								if (load_count_q[ENT_AW]) begin
									ovf_q <= 1'b1;
								end else begin
									load_count_q <= load_count_q + CNT_W'(1);
								end
							end
							OP_BUILD: begin
								n_q     <= load_count_q;
								k_q     <= '0;
								bad_q   <= 1'b0;
								state_q <= (load_count_q == '0) ? S_CHK_END : S_CHK_A;
							end
							OP_READ_OFF: begin
								if (position <= {2'b00, nr}) begin
									state_q <= S_RD_OFF;
								end else begin
									out_valid_q <= 1'b1;
									status_q    <= ST_OOB;
									value_q     <= '0;
								end
							end
							OP_READ_COL: begin
								if (position < built_q) begin
									state_q <= S_RD_COL;
								end else begin
									out_valid_q <= 1'b1;
									status_q    <= ST_OOB;
									value_q     <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD_OFF: begin
					out_valid_q <= 1'b1;
					status_q    <= ST_OK;
					value_q     <= 16'(off_rdata);
					state_q     <= S_IDLE;
				end
				S_RD_COL: begin
					out_valid_q <= 1'b1;
					status_q    <= ST_OK;
					value_q     <= cs_rdata;
					state_q     <= S_IDLE;
				end
				S_CHK_A: begin
					state_q <= S_CHK_B;
				end
				S_CHK_B: begin
					if (({1'b0, rows_rdata} >= nr) || ({1'b0, cols_rdata} >= num_cols_q)) begin
						bad_q <= 1'b1;
					end
					k_q     <= k_q + CNT_W'(1);
					state_q <= (k_q == n_q - CNT_W'(1)) ? S_CHK_END : S_CHK_A;
				end
				S_CHK_END: begin
					if (bad_q) begin
						st_q <= ST_OOB;
					end else if (ovf_q) begin
						st_q <= ST_OVERFLOW;
					end else if (n_q == '0) begin
						st_q <= ST_EMPTY;
					end else begin
						st_q <= ST_OK;
					end
					load_count_q <= '0;
					ovf_q        <= 1'b0;
					built_q      <= '0;
					clr_q        <= '0;
					state_q      <= S_CLR;
				end
				S_CNT_A: begin
					state_q <= S_CNT_B;
				end
				S_CNT_B: begin
					row_q   <= rows_rdata;
					state_q <= S_CNT_C;
				end
				S_CNT_C: begin
					state_q <= S_CNT_D;
				end
				S_CNT_D: begin
					k_q <= k_q + CNT_W'(1);
					if (k_q == n_q - CNT_W'(1)) begin
						i_q     <= '0;
						run_q   <= '0;
						state_q <= S_SCAN_A;
					end else begin
						state_q <= S_CNT_A;
					end
				end
				S_SCAN_A: begin
					state_q <= S_SCAN_B;
				end
				S_SCAN_B: begin
					run_q <= run_q + off_rdata;
					if (i_q == nr) begin
						k_q     <= '0;
						state_q <= S_SCAT_A;
					end else begin
						i_q     <= i_q + OFF_AW'(1);
						state_q <= S_SCAN_A;
					end
				end
				S_SCAT_A: begin
					state_q <= S_SCAT_B;
				end
				S_SCAT_B: begin
					row_q   <= rows_rdata;
					col_q   <= cols_rdata;
					state_q <= S_SCAT_C;
				end
				S_SCAT_C: begin
					state_q <= S_SCAT_D;
				end
				S_SCAT_D: begin
					if (k_q == n_q - CNT_W'(1)) begin
						k_q <= '0;
						if (!sorted_q) begin
							i_q     <= '0;
							w_q     <= n_q;
							state_q <= S_SRT_R;
						end else if (!no_dups_q) begin
							i_q     <= '0;
							w_q     <= '0;
							state_q <= S_DED_R;
						end else begin
							i_q     <= nr;
							w_q     <= n_q;
							state_q <= S_FILL;
						end
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_SCAT_A;
					end
				end
				S_SRT_R: begin
					state_q <= S_SRT_RB;
				end
				S_SRT_RB: begin
					// begin of row from the offsets, end from the advanced cursor
					b_q     <= off_rdata;
					e_q     <= cur_rdata;
					a_q     <= off_rdata + CNT_W'(1);
					state_q <= S_SRT_A;
				end
				S_SRT_A: begin
					if (a_q >= e_q) begin
						if (i_q + OFF_AW'(1) == nr) begin
							if (!no_dups_q) begin
								i_q     <= '0;
								w_q     <= '0;
								k_q     <= '0;
								state_q <= S_DED_R;
							end else begin
								i_q     <= nr;
								state_q <= S_FILL;
							end
						end else begin
							i_q     <= i_q + OFF_AW'(1);
							state_q <= S_SRT_R;
						end
					end else begin
						state_q <= S_SRT_V;
					end
				end
				S_SRT_V: begin
					v_q     <= cs_rdata;
					p_q     <= a_q;
					state_q <= S_SRT_P;
				end
				S_SRT_P: begin
					if (p_q > b_q) begin
						state_q <= S_SRT_C;
					end else begin
						a_q     <= a_q + CNT_W'(1);
						state_q <= S_SRT_A;
					end
				end
				S_SRT_C: begin
					if (cs_rdata > v_q) begin
						p_q     <= p_q - CNT_W'(1);
						state_q <= S_SRT_P;
					end else begin
						a_q     <= a_q + CNT_W'(1);
						state_q <= S_SRT_A;
					end
				end
				S_DED_R: begin
					state_q <= S_DED_E;
				end
				S_DED_E: begin
					e_q     <= cur_rdata;
					b_q     <= k_q;
					state_q <= S_DED_K;
				end
				S_DED_K: begin
					if (k_q >= e_q) begin
						if (i_q + OFF_AW'(1) == nr) begin
							i_q     <= nr;
							state_q <= S_FILL;
						end else begin
							i_q     <= i_q + OFF_AW'(1);
							state_q <= S_DED_R;
						end
					end else begin
						state_q <= S_DED_D;
					end
				end
				S_DED_D: begin
					// prev holds the column before compaction
					prev_q <= cs_rdata;
					if ((k_q == b_q) || (cs_rdata != prev_q)) begin
						w_q <= w_q + CNT_W'(1);
					end
					k_q     <= k_q + CNT_W'(1);
					state_q <= S_DED_K;
				end
				S_FILL: begin
					i_q <= i_q + OFF_AW'(1);
					if (i_q == OFF_AW'(MAX_ROWS)) begin
						built_q     <= w_q;
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						value_q     <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

@@ rtl/c2c_checker.sv @@
// Port-level checker for the COO to CSR builder, bound to the top level.
`include "assert_macros.svh"

module c2c_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  opcode,
	input logic [7:0]  row,
	input logic [15:0] col,
	input logic [10:0] position,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [15:0] value,
	input logic [10:0] nonzeros,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [16:0] cfg_data
);
	import c2c_pkg::*;

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, out_valid && out_stall,
		$stable(status) && $stable(value) && $stable(nonzeros))
	`ASSERT_NEXT(a_load_silent, in_valid && !in_stall && opcode == OP_LOAD, !out_valid)
	`ASSERT_IMPL(a_fail_zero, out_valid && status != ST_OK, value == 16'd0)
endmodule

bind coo_to_csr_builder_core c2c_checker u_c2c_checker (.*);
